/* src/plr_pkg.sv */
// Shared types, constants and codes of the per-address rate limiter.
package plr_pkg;

  // Table size default and configuration reset values
  localparam int TABLE_ENTRIES_DEF = 256;
  localparam logic [15:0] MAX_PER_WINDOW_RST = 16'd100;
  localparam logic [31:0] WINDOW_SECONDS_RST = 32'd3600;

  // Configuration port geometry and register indexes
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_MAX_PER_WINDOW = 1'b0;
  localparam logic REG_WINDOW_SECONDS = 1'b1;

  // Result field widths
  localparam int SLOT_W = 8;
  localparam int OUTCOME_W = 2;

  // Outcome codes
  localparam logic [OUTCOME_W-1:0] OUTCOME_HIT_ALLOWED = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_HIT_REFUSED = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_NEW_SLOT = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUTCOME_EVICTED = 2'd3;

  // One table entry as held in memory
  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [63:0] start_time;
    logic [15:0] req_count;
  } plr_entry_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic check;
    logic commit;
  } plr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } plr_sts_t;

endpackage

/* src/plr_if.sv */
// Request and result channel interfaces of the rate limiter.
interface plr_req_if;
  logic        valid;
  logic        ready;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic signed [63:0] now_seconds;

  modport source (output valid, addr_high, addr_low, now_seconds, input ready);
  modport sink (input valid, addr_high, addr_low, now_seconds, output ready);
endinterface

interface plr_rsp_if;
  logic       valid;
  logic       ready;
  logic       allowed;
  logic [1:0] outcome;
  logic [7:0] slot;

  modport source (output valid, allowed, outcome, slot, input ready);
  modport sink (input valid, allowed, outcome, slot, output ready);
endinterface

/* src/plr_cfg.sv */
// APB-style configuration registers of the rate limiter.
module plr_cfg
  import plr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [15:0]        max_per_window,
  output logic [31:0]        window_seconds
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // Write registers on the access cycle of a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      max_per_window <= MAX_PER_WINDOW_RST;
      window_seconds <= WINDOW_SECONDS_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_MAX_PER_WINDOW: max_per_window <= pwdata[15:0];
        REG_WINDOW_SECONDS: window_seconds <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    case (reg_sel)
      REG_MAX_PER_WINDOW: prdata = {16'b0, max_per_window};
      REG_WINDOW_SECONDS: prdata = window_seconds;
      default:            prdata = '0;
    endcase
  end

endmodule

/* src/plr_ctrl.sv */
// Controller state machine: accept, scan, check window, commit result.
module plr_ctrl
  import plr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  plr_sts_t sts,
  output plr_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_CHECK  = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode commands and advance the sequence
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* src/plr_dp.sv */
// Datapath: address table memory, serial scan, window check and update.
module plr_dp
  import plr_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  plr_cmd_t             cmd,
  output plr_sts_t             sts,
  input  logic [63:0]          in_addr_high,
  input  logic [63:0]          in_addr_low,
  input  logic [63:0]          in_now,
  input  logic [15:0]          max_per_window,
  input  logic [31:0]          window_seconds,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_allowed,
  output logic [OUTCOME_W-1:0] out_outcome,
  output logic [SLOT_W-1:0]    out_slot
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

  plr_entry_t mem [TABLE_ENTRIES];
  plr_entry_t rd_data;
  plr_entry_t wr_data;

  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] rd_idx;
  logic             rd_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic             issue;

  logic [63:0] req_high;
  logic [63:0] req_low;
  logic [63:0] req_now;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [63:0]      hit_start;
  logic [15:0]      hit_count;
  logic [IDX_W-1:0] min_idx;
  logic [63:0]      min_start;
  logic             expired;

  logic             full;
  logic [15:0]      count_eff;
  logic             refuse;
  logic [IDX_W-1:0] wr_idx;
  logic [OUTCOME_W-1:0] outcome_c;
  logic [IDX_W+SLOT_W-1:0] slot_ext;
  logic [63:0]      diff;

  // Issue one read per scan cycle until a hit or the end of filled slots
  assign issue = cmd.scan && !hit && (rd_idx != entry_count);

  assign sts.scan_done = hit || ((rd_idx == entry_count) && !rd_valid);
  assign sts.out_busy  = out_valid && !out_ready;

  // Table memory: one registered read port, one write port
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[rd_idx[IDX_W-1:0]];
    end
    if (cmd.commit) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Scan control and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid    <= 1'b0;
      hit         <= 1'b0;
      entry_count <= '0;
      out_valid   <= 1'b0;
      rd_idx      <= '0;
    end else begin
      if (cmd.load) begin
        rd_idx   <= '0;
        rd_valid <= 1'b0;
        hit      <= 1'b0;
      end else if (cmd.scan) begin
        rd_valid <= issue;
        if (issue) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
        if (rd_valid && !hit && rd_data.addr_high == req_high
            && rd_data.addr_low == req_low) begin
          hit <= 1'b1;
        end
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (!hit && !full) begin
          entry_count <= entry_count + CNT_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture request, match entry and oldest window start
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_high <= in_addr_high;
      req_low  <= in_addr_low;
      req_now  <= in_now;
    end
    if (cmd.scan) begin
      if (issue) begin
        cmp_idx <= rd_idx[IDX_W-1:0];
      end
      if (rd_valid && !hit) begin
        if (rd_data.addr_high == req_high && rd_data.addr_low == req_low) begin
          hit_idx   <= cmp_idx;
          hit_start <= rd_data.start_time;
          hit_count <= rd_data.req_count;
        end
        if (cmp_idx == '0
            || $signed(rd_data.start_time) < $signed(min_start)) begin
          min_idx   <= cmp_idx;
          min_start <= rd_data.start_time;
        end
      end
    end
    if (cmd.check) begin
      expired <= !($signed(req_now) < $signed(hit_start))
                 && (diff > {32'b0, window_seconds});
    end
  end

  assign diff = req_now - hit_start;

  // Decide outcome and build the entry to write back
  always_comb begin
    full      = (entry_count == FULL_COUNT);
    count_eff = expired ? 16'd0 : hit_count;
    refuse    = (count_eff >= max_per_window);
    wr_data.addr_high = req_high;
    wr_data.addr_low  = req_low;
    if (hit) begin
      wr_data.start_time = expired ? req_now : hit_start;
      wr_data.req_count  = refuse ? count_eff : count_eff + 16'd1;
      wr_idx             = hit_idx;
      outcome_c          = refuse ? OUTCOME_HIT_REFUSED : OUTCOME_HIT_ALLOWED;
    end else begin
      wr_data.start_time = req_now;
      wr_data.req_count  = 16'd1;
      wr_idx             = full ? min_idx : entry_count[IDX_W-1:0];
      outcome_c          = full ? OUTCOME_EVICTED : OUTCOME_NEW_SLOT;
    end
    slot_ext = {{SLOT_W{1'b0}}, wr_idx};
  end

  // Hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_allowed <= !(hit && refuse);
      out_outcome <= outcome_c;
      out_slot    <= slot_ext[SLOT_W-1:0];
    end
  end

endmodule

/* src/per_address_rate_limiter_top.sv */
// Per-address fixed-window rate limiter: top level.
// The scan reads the table serially over the filled slots
// (one table read per cycle during the scan; a hit ends the scan early).
// A new request is taken only after the previous one has been committed.
// A finished result waits in the output register while the next request is taken.
// Reset empties the table (entry count zero) and restores both config registers.
module per_address_rate_limiter_top
  import plr_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  plr_req_if.sink            req,
  plr_rsp_if.source          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [15:0] max_per_window;
  logic [31:0] window_seconds;
  plr_cmd_t    cmd;
  plr_sts_t    sts;

  plr_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .max_per_window (max_per_window),
    .window_seconds (window_seconds)
  );

  plr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  plr_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_addr_high   (req.addr_high),
    .in_addr_low    (req.addr_low),
    .in_now         (req.now_seconds),
    .max_per_window (max_per_window),
    .window_seconds (window_seconds),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_allowed    (rsp.allowed),
    .out_outcome    (rsp.outcome),
    .out_slot       (rsp.slot)
  );

endmodule

/* dv/per_address_rate_limiter_top_test.sv */
// Self-checking testbench of the per-address rate limiter: directed rows, then random traffic.
module per_address_rate_limiter_top_test
  import plr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYCLES = TABLE_ENTRIES_DEF + 10;
  localparam int LONG_HOLD = 1500;
  localparam int POOL_SIZE = 300;
  localparam int HOT_SIZE = 8;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int N_ROWS = 21;

  localparam logic [63:0] T_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {ROW_REQ, ROW_SET_LIMIT, ROW_SET_WINDOW} row_kind_t;

  typedef struct packed {
    logic                 allowed;
    logic [OUTCOME_W-1:0] outcome;
    logic [SLOT_W-1:0]    slot;
  } verdict_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] now;
    logic [31:0] value;
    logic        typed;
    verdict_t    want;
  } plan_row_t;

  localparam verdict_t NO_VERDICT = '0;

  // Directed rows: boundaries of the window compare, time extremes, partial address
  // matches, a zero limit and the widest settings. Eviction comes with the random part.
  localparam plan_row_t PLAN [N_ROWS] = '{
    '{ROW_REQ, 64'd0, 64'd0, 64'd0, 32'd0, 1'b1, {1'b1, OUTCOME_NEW_SLOT, 8'd0}},
    '{ROW_REQ, ONES, ONES, T_MAX, 32'd0, 1'b1, {1'b1, OUTCOME_NEW_SLOT, 8'd1}},
    '{ROW_REQ, 64'd0, 64'd0, 64'd0, 32'd0, 1'b1, {1'b1, OUTCOME_HIT_ALLOWED, 8'd0}},
    '{ROW_SET_LIMIT, 64'd0, 64'd0, 64'd0, 32'd1, 1'b0, NO_VERDICT},
    '{ROW_REQ, 64'd0, 64'd0, 64'd3600, 32'd0, 1'b1, {1'b0, OUTCOME_HIT_REFUSED, 8'd0}},
    '{ROW_REQ, 64'd0, 64'd0, 64'd3601, 32'd0, 1'b1, {1'b1, OUTCOME_HIT_ALLOWED, 8'd0}},
    '{ROW_REQ, ONES, ONES, T_MIN, 32'd0, 1'b1, {1'b0, OUTCOME_HIT_REFUSED, 8'd1}},
    '{ROW_REQ, ONES, 64'd0, T_MIN, 32'd0, 1'b1, {1'b1, OUTCOME_NEW_SLOT, 8'd2}},
    '{ROW_REQ, ONES, 64'd0, T_MAX, 32'd0, 1'b1, {1'b1, OUTCOME_HIT_ALLOWED, 8'd2}},
    '{ROW_REQ, 64'd0, ONES, 64'd0, 32'd0, 1'b1, {1'b1, OUTCOME_NEW_SLOT, 8'd3}},
    '{ROW_SET_LIMIT, 64'd0, 64'd0, 64'd0, 32'd0, 1'b0, NO_VERDICT},
    '{ROW_REQ, 64'd0, 64'd0, 64'd100000, 32'd0, 1'b1, {1'b0, OUTCOME_HIT_REFUSED, 8'd0}},
    '{ROW_REQ, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'd5, 32'd0, 1'b1,
      {1'b1, OUTCOME_NEW_SLOT, 8'd4}},
    '{ROW_SET_WINDOW, 64'd0, 64'd0, 64'd0, 32'd0, 1'b0, NO_VERDICT},
    '{ROW_SET_LIMIT, 64'd0, 64'd0, 64'd0, 32'd65535, 1'b0, NO_VERDICT},
    '{ROW_REQ, 64'd0, ONES, 64'd1, 32'd0, 1'b1, {1'b1, OUTCOME_HIT_ALLOWED, 8'd3}},
    '{ROW_REQ, 64'd0, ONES, 64'd1, 32'd0, 1'b1, {1'b1, OUTCOME_HIT_ALLOWED, 8'd3}},
    '{ROW_SET_WINDOW, 64'd0, 64'd0, 64'd0, 32'hFFFF_FFFF, 1'b0, NO_VERDICT},
    '{ROW_REQ, 64'd0, ONES, 64'h1_0000_0000, 32'd0, 1'b0, NO_VERDICT},
    '{ROW_REQ, 64'd0, ONES, 64'h1_0000_0001, 32'd0, 1'b0, NO_VERDICT},
    '{ROW_REQ, ONES, ONES, 64'd0, 32'd0, 1'b0, NO_VERDICT}
  };

  localparam logic [15:0] PHASE_LIMIT [N_PHASES-1] = '{3, 1, 65535, 0, 2, 100, 5};
  localparam logic [31:0] PHASE_WINDOW [N_PHASES-1] =
    '{10, 1, 32'hFFFF_FFFF, 5, 0, 3600, 50};

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  plr_req_if req_ch ();
  plr_rsp_if rsp_ch ();

  per_address_rate_limiter_top dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the limiter state
  logic [63:0] known_hi [N_ENTRIES];
  logic [63:0] known_lo [N_ENTRIES];
  logic [63:0] start_time [N_ENTRIES];
  logic [15:0] hit_count [N_ENTRIES];
  int          filled = 0;
  logic [15:0] limit_cfg = MAX_PER_WINDOW_RST;
  logic [31:0] window_cfg = WINDOW_SECONDS_RST;

  verdict_t pending_verdicts [$];
  verdict_t oldest_verdict;
  int       verdicts_seen = 0;
  int       mismatch_count = 0;
  bit       quiet_sender = 1'b0;

  // Work out the verdict for one request and advance the shadow table
  function automatic verdict_t predict_verdict(input logic [63:0] hi, lo, now);
    verdict_t          v;
    int                idx;
    logic signed [64:0] elapsed;
    v = '{allowed: 1'b1, outcome: OUTCOME_NEW_SLOT, slot: '0};
    idx = -1;
    for (int i = 0; i < filled; i++) begin
      if (idx < 0 && known_hi[i] == hi && known_lo[i] == lo) idx = i;
    end
    if (idx >= 0) begin
      // restart the window only when strictly more than window_cfg seconds went by
      elapsed = $signed({now[63], now}) - $signed({start_time[idx][63], start_time[idx]});
      if (!elapsed[64] && elapsed[63:0] > {32'd0, window_cfg}) begin
        start_time[idx] = now;
        hit_count[idx] = '0;
      end
      if (hit_count[idx] >= limit_cfg) begin
        v.allowed = 1'b0;
        v.outcome = OUTCOME_HIT_REFUSED;
      end else begin
        hit_count[idx] = hit_count[idx] + 16'd1;
        v.outcome = OUTCOME_HIT_ALLOWED;
      end
    end else begin
      if (filled < N_ENTRIES) begin
        idx = filled;
        filled++;
      end else begin
        // replace the oldest window start, lowest index on a tie
        idx = 0;
        v.outcome = OUTCOME_EVICTED;
        for (int i = 1; i < N_ENTRIES; i++) begin
          if ($signed(start_time[i]) < $signed(start_time[idx])) idx = i;
        end
      end
      known_hi[idx] = hi;
      known_lo[idx] = lo;
      start_time[idx] = now;
      hit_count[idx] = 16'd1;
    end
    v.slot = idx[SLOT_W-1:0];
    return v;
  endfunction

  // Offer one request, predict at the transfer, then idle for a random gap
  task automatic offer_request(input logic [63:0] hi, lo, now, input logic typed,
                               input verdict_t want);
    verdict_t v;
    int       gap;
    int       r;
    req_ch.valid <= 1'b1;
    req_ch.addr_high <= hi;
    req_ch.addr_low <= lo;
    req_ch.now_seconds <= now;
    do @(posedge clk); while (!req_ch.ready);
    v = predict_verdict(hi, lo, now);
    pending_verdicts.push_back(typed ? want : v);
    r = $urandom_range(0, 99);
    if (quiet_sender || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every outstanding result, then let the block settle
  task automatic settle(input int cycles);
    req_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  // Read a register back and compare it with the shadow copy
  task automatic check_reg(input logic idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_MAX_PER_WINDOW) begin
      if (prdata[15:0] !== limit_cfg) begin
        $error("max_per_window mismatch: expected %0d, got %0d", limit_cfg, prdata[15:0]);
        mismatch_count++;
      end
    end else if (prdata[31:0] !== window_cfg) begin
      $error("window_seconds mismatch: expected %0d, got %0d", window_cfg, prdata[31:0]);
      mismatch_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register, update the shadow copy and read it back
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_MAX_PER_WINDOW) limit_cfg = value[15:0];
    else window_cfg = value;
    check_reg(idx);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls, quiet stretches, and one long hold-off
  initial begin
    int stall;
    int mode_left;
    bit steady;
    bit held_long;
    stall = 0;
    mode_left = 0;
    steady = 1'b0;
    held_long = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        mode_left = 200;
      end
      mode_left--;
      if (!held_long && verdicts_seen >= 500) begin
        held_long = 1'b1;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 99) < 15) begin
        stall = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 60);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Check every result transfer against the oldest pending verdict
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        $error("result transfer with no request pending: slot %0d", rsp_ch.slot);
        mismatch_count++;
      end else begin
        oldest_verdict = pending_verdicts.pop_front();
        if (rsp_ch.allowed !== oldest_verdict.allowed) begin
          $error("allowed mismatch: expected %0d, got %0d", oldest_verdict.allowed,
                 rsp_ch.allowed);
          mismatch_count++;
        end
        if (rsp_ch.outcome !== oldest_verdict.outcome) begin
          $error("outcome mismatch: expected %0d, got %0d", oldest_verdict.outcome,
                 rsp_ch.outcome);
          mismatch_count++;
        end
        if (rsp_ch.slot !== oldest_verdict.slot) begin
          $error("slot mismatch: expected %0d, got %0d", oldest_verdict.slot, rsp_ch.slot);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [63:0] pool_hi [POOL_SIZE];
    logic [63:0] pool_lo [POOL_SIZE];
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] clock_now;
    logic [63:0] span;
    logic [15:0] lim;
    logic [31:0] win;
    int          r;
    int          pick;

    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.addr_high <= '0;
    req_ch.addr_low <= '0;
    req_ch.now_seconds <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values of both registers
    check_reg(REG_MAX_PER_WINDOW);
    check_reg(REG_WINDOW_SECONDS);

    // walk the directed rows
    for (int row = 0; row < N_ROWS; row++) begin
      case (PLAN[row].kind)
        ROW_REQ: begin
          offer_request(PLAN[row].hi, PLAN[row].lo, PLAN[row].now, PLAN[row].typed,
                        PLAN[row].want);
        end
        ROW_SET_LIMIT: begin
          settle(4);
          write_reg(REG_MAX_PER_WINDOW, PLAN[row].value);
        end
        default: begin
          settle(4);
          write_reg(REG_WINDOW_SECONDS, PLAN[row].value);
        end
      endcase
    end

    // address pool; neighbors share one half to probe the two-part compare
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
      if (i % 3 == 1) pool_hi[i] = pool_hi[i-1];
      if (i % 3 == 2) pool_lo[i] = pool_lo[i-1];
    end
    clock_now = '0;

    // random phases, one register setting each
    for (int p = 0; p < N_PHASES; p++) begin
      if (p < N_PHASES - 1) begin
        lim = PHASE_LIMIT[p];
        win = PHASE_WINDOW[p];
      end else begin
        lim = 16'($urandom_range(1, 6));
        win = $urandom;
      end
      settle(4);
      write_reg(REG_MAX_PER_WINDOW, {16'd0, lim});
      write_reg(REG_WINDOW_SECONDS, win);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 50 == 0) quiet_sender = ($urandom_range(0, 3) == 0);

        // mostly a small hot set for refusals, then the pool to fill and evict
        r = $urandom_range(0, 99);
        pick = (r < 55) ? $urandom_range(0, HOT_SIZE - 1) : $urandom_range(0, POOL_SIZE - 1);
        hi = pool_hi[pick];
        lo = pool_lo[pick];
        if (r >= 85 && r < 95) begin
          hi = {$urandom, $urandom};
          lo = {$urandom, $urandom};
        end else if (r >= 95) begin
          lo = {$urandom, $urandom};
        end

        // advance time: small steps for ties, window-sized steps, jumps and extremes
        r = $urandom_range(0, 99);
        if (r < 40) begin
          clock_now += 64'($urandom_range(0, 3));
        end else if (r < 70) begin
          span = 2 * {32'd0, window_cfg} + 64'd3;
          clock_now += {$urandom, $urandom} % span;
        end else if (r < 80) begin
          clock_now += {32'd0, window_cfg} + 64'($urandom_range(0, 1));
        end else if (r < 88) begin
          clock_now -= 64'($urandom_range(0, 50));
        end else if (r < 96) begin
          clock_now = {$urandom, $urandom};
        end else begin
          clock_now = ($urandom_range(0, 1) == 1) ? T_MIN : T_MAX;
        end

        offer_request(hi, lo, clock_now, 1'b0, NO_VERDICT);
      end
    end
    quiet_sender = 1'b0;

    settle(DRAIN_CYCLES);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
